// ===== src/set_assoc_transposition_table_core_defines.svh =====
// assertion macros for the transposition table core
// used by set_assoc_transposition_table_core.sv, no other dependencies
`ifndef SET_ASSOC_TRANSPOSITION_TABLE_CORE_DEFINES_SVH
`define SET_ASSOC_TRANSPOSITION_TABLE_CORE_DEFINES_SVH

// condition that must hold at every clock edge outside reset
`define STT_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// condition that must hold in the cycle after the trigger
`define STT_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

// ===== src/stt_pkg.sv =====
// shared types and constants of the transposition table core
// no dependencies
package stt_pkg;

    localparam int TAG_W      = 32;
    localparam int SCORE_W    = 32;
    localparam int MOVE_W     = 24;
    localparam int BTYPE_W    = 8;
    localparam int DEPTH_W    = 8;
    localparam int GEN_W      = 16;
    localparam int MATE_W     = 31;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_STORE  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_MATE_THRESHOLD  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DRAW_SCORE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INFINITY_SCORE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_TYPE_CODE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NULL_MOVE_CODE  = 3'd4;

    localparam logic [MATE_W-1:0]     RST_MATE_THRESHOLD  = 31'd30000;
    localparam logic [SCORE_W-1:0]    RST_DRAW_SCORE      = 32'd0;
    localparam logic [SCORE_W-1:0]    RST_INFINITY_SCORE  = 32'd32000;
    localparam logic [BTYPE_W-1:0]    RST_ALPHA_TYPE_CODE = 8'd1;
    localparam logic [MOVE_W-1:0]     RST_NULL_MOVE_CODE  = 24'd0;

    typedef struct packed {
        logic [TAG_W-1:0]          tag;
        logic signed [SCORE_W-1:0] score;
        logic [MOVE_W-1:0]         move;
        logic [BTYPE_W-1:0]        btype;
        logic signed [DEPTH_W-1:0] depth;
        logic [GEN_W-1:0]          gen;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

// ===== src/stt_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module stt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/set_assoc_transposition_table_core.sv =====
// set-associative transposition table: one ram row per set holds all ways
// depends on stt_pkg, stt_ram and set_assoc_transposition_table_core_defines.svh
// a lookup result is registered onto the master side after its row is read and compared
// a new request is taken only in idle, so the read then write-back of one ram row ends first;
// a lookup waits in the compare cycle while an earlier result is still not taken
// reset: synchronous, then every row is cleared in ST_CLEAR with tready low
`include "set_assoc_transposition_table_core_defines.svh"

module set_assoc_transposition_table_core import stt_pkg::*; #(
    parameter int SET_BITS = 12,
    parameter int WAYS     = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // position_key, score, move_code, bound_type, search_generation, search_depth
    input  logic [151:0]          s_axis_tdata,
    // operation
    input  logic [0:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // found_score, found_move, found_type, found_depth
    output logic [71:0]           m_axis_tdata,
    // hit
    output logic [0:0]            m_axis_tuser,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int NUM_SETS = 1 << SET_BITS;
    localparam int ROW_W    = WAYS * ENTRY_W;
    localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;

    typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_RD} t_state;

    t_state r_state;
    logic [SET_BITS-1:0]       r_clr_addr;

    logic [MATE_W-1:0]         r_mate;
    logic [SCORE_W-1:0]        r_draw;
    logic [SCORE_W-1:0]        r_inf;
    logic [BTYPE_W-1:0]        r_alpha;
    logic [MOVE_W-1:0]         r_null;

    logic                      r_op;
    logic                      r_store_en;
    logic [SET_BITS-1:0]       r_set;
    logic [TAG_W-1:0]          r_tag;
    logic [SCORE_W-1:0]        r_wscore;
    logic [MOVE_W-1:0]         r_move;
    logic [BTYPE_W-1:0]        r_wtype;
    logic [GEN_W-1:0]          r_gen;
    logic [DEPTH_W-1:0]        r_depth;

    logic                      r_out_valid;
    logic                      r_out_hit;
    logic [71:0]               r_out_data;

    logic [TAG_W-1:0]          in_tag;
    logic [SCORE_W-1:0]        in_score;
    logic [MOVE_W-1:0]         in_move;
    logic [BTYPE_W-1:0]        in_type;
    logic [GEN_W-1:0]          in_gen;
    logic signed [DEPTH_W-1:0] in_depth;
    logic                      accept;
    logic                      n_subst;

    logic                      ram_we;
    logic [SET_BITS-1:0]       ram_waddr;
    logic [ROW_W-1:0]          ram_wdata;
    logic [SET_BITS-1:0]       ram_raddr;
    logic [ROW_W-1:0]          ram_rdata;

    t_entry                    c_way [WAYS];
    logic                      c_hit;
    logic [WAY_W-1:0]          c_hit_way;
    logic [WAY_W-1:0]          c_victim;
    logic [ROW_W-1:0]          n_wrow;
    logic                      out_load;
    logic                      out_free;

    assign in_tag   = s_axis_tdata[63:32];
    assign in_score = s_axis_tdata[95:64];
    assign in_move  = s_axis_tdata[119:96];
    assign in_type  = s_axis_tdata[127:120];
    assign in_gen   = s_axis_tdata[143:128];
    assign in_depth = s_axis_tdata[151:144];

    assign s_axis_tready = (r_state == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // mate or draw score check, done as the request is taken
    always_comb begin
        logic signed [SCORE_W:0] val;
        logic signed [SCORE_W:0] mate;
        val     = {in_score[SCORE_W-1], in_score};
        mate    = {2'b00, r_mate};
        n_subst = (val >= mate) || (val <= -mate) || (in_score == r_draw);
    end

    stt_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_SETS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // tag compare, hit way, victim choice and the new row to write back, over the read row
    always_comb begin
        logic                      found_old;
        logic                      found_any;
        logic signed [DEPTH_W-1:0] best_old;
        logic signed [DEPTH_W-1:0] best_any;
        logic [WAY_W-1:0]          v_old;
        logic [WAY_W-1:0]          v_any;
        t_entry                    ne;
        found_old = 1'b0;
        found_any = 1'b0;
        best_old  = '0;
        best_any  = '0;
        v_old     = '0;
        v_any     = '0;
        c_hit     = 1'b0;
        c_hit_way = '0;
        for (int w = 0; w < WAYS; w++) begin
            c_way[w] = t_entry'(ram_rdata[w*ENTRY_W +: ENTRY_W]);
        end
        for (int w = 0; w < WAYS; w++) begin
            if (!c_hit && c_way[w].tag == r_tag) begin
                c_hit     = 1'b1;
                c_hit_way = WAY_W'(w);
            end
            if (c_way[w].gen != r_gen && (!found_old || c_way[w].depth < best_old)) begin
                found_old = 1'b1;
                best_old  = c_way[w].depth;
                v_old     = WAY_W'(w);
            end
            if (!found_any || c_way[w].depth < best_any) begin
                found_any = 1'b1;
                best_any  = c_way[w].depth;
                v_any     = WAY_W'(w);
            end
        end
        priority if (c_hit) begin
            c_victim = c_hit_way;
        end else if (found_old) begin
            c_victim = v_old;
        end else begin
            c_victim = v_any;
        end
        ne.tag   = r_tag;
        ne.score = r_wscore;
        ne.move  = (c_hit && r_move == r_null) ? c_way[c_hit_way].move : r_move;
        ne.btype = r_wtype;
        ne.depth = r_depth;
        ne.gen   = r_gen;
        n_wrow   = ram_rdata;
        n_wrow[c_victim*ENTRY_W +: ENTRY_W] = ne;
    end

    always_comb begin
        unique case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_addr;
                ram_wdata = '0;
                ram_raddr = s_axis_tdata[SET_BITS-1:0];
            end
            ST_RD: begin
                ram_we    = (r_op == OP_STORE) && r_store_en;
                ram_waddr = r_set;
                ram_wdata = n_wrow;
                ram_raddr = r_set;
            end
            default: begin
                ram_we    = 1'b0;
                ram_waddr = r_set;
                ram_wdata = n_wrow;
                ram_raddr = s_axis_tdata[SET_BITS-1:0];
            end
        endcase
    end

    assign out_free = !r_out_valid || m_axis_tready;
    assign out_load = (r_state == ST_RD) && (r_op == OP_LOOKUP) && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
            r_mate      <= RST_MATE_THRESHOLD;
            r_draw      <= RST_DRAW_SCORE;
            r_inf       <= RST_INFINITY_SCORE;
            r_alpha     <= RST_ALPHA_TYPE_CODE;
            r_null      <= RST_NULL_MOVE_CODE;
            r_op        <= OP_LOOKUP;
            r_store_en  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_MATE_THRESHOLD:  r_mate  <= i_cfg_data[MATE_W-1:0];
                    CFG_DRAW_SCORE:      r_draw  <= i_cfg_data[SCORE_W-1:0];
                    CFG_INFINITY_SCORE:  r_inf   <= i_cfg_data[SCORE_W-1:0];
                    CFG_ALPHA_TYPE_CODE: r_alpha <= i_cfg_data[BTYPE_W-1:0];
                    CFG_NULL_MOVE_CODE:  r_null  <= i_cfg_data[MOVE_W-1:0];
                    default: ;
                endcase
            end

            if (m_axis_tready && r_out_valid && !out_load) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (&r_clr_addr) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        r_state    <= ST_RD;
                        r_op       <= s_axis_tuser[0];
                        r_store_en <= (in_depth > 0);
                        r_set      <= s_axis_tdata[SET_BITS-1:0];
                        r_tag      <= in_tag;
                        r_wscore   <= n_subst ? r_inf : in_score;
                        r_wtype    <= n_subst ? r_alpha : in_type;
                        r_move     <= in_move;
                        r_gen      <= in_gen;
                        r_depth    <= in_depth;
                    end
                end
                ST_RD: begin
                    if ((r_op == OP_STORE) || out_free) begin
                        r_state <= ST_IDLE;
                    end
                    if (out_load) begin
                        r_out_valid <= 1'b1;
                        r_out_hit   <= c_hit;
                        if (c_hit) begin
                            r_out_data <= {c_way[c_hit_way].depth, c_way[c_hit_way].btype,
                                           c_way[c_hit_way].move, c_way[c_hit_way].score};
                        end else begin
                            r_out_data <= '0;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_out_data;
    assign m_axis_tuser[0] = r_out_hit;

    `STT_ASSERT_NEXT(a_accept_to_read, accept, r_state == ST_RD, "request not followed by row read")
    `STT_ASSERT_NEXT(a_store_one_cycle, (r_state == ST_RD) && (r_op == OP_STORE), r_state == ST_IDLE,
        "store did not finish in one compare cycle")
    `STT_ASSERT_NEXT(a_lookup_result, (r_state == ST_RD) && (r_op == OP_LOOKUP) && !r_out_valid,
        r_out_valid, "lookup with free output gave no result")
    `STT_ASSERT_ALWAYS(a_ram_write_phase, !ram_we || r_state == ST_CLEAR || r_op == OP_STORE,
        "ram written outside clearing or store")

endmodule

// ===== tb/set_assoc_transposition_table_core_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for set_assoc_transposition_table_core: directed and random requests
// keeps its own model of every set and way to predict each lookup result
// depends on stt_pkg and set_assoc_transposition_table_core

module set_assoc_transposition_table_core_tb import stt_pkg::*; ();

    localparam int SETS_LOG2     = 12;
    localparam int WAY_COUNT     = 4;
    localparam int ENTRY_COUNT   = (1 << SETS_LOG2) * WAY_COUNT;
    localparam int NO_DEPTH      = 999;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int PHASE_COUNT   = 3;
    localparam int PHASE_ITEMS   = 510;
    localparam int PRINT_LIMIT   = 40;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 3'd7;

    typedef struct packed {
        logic                      hit;
        logic signed [SCORE_W-1:0] score;
        logic [MOVE_W-1:0]         move;
        logic [BTYPE_W-1:0]        btype;
        logic signed [DEPTH_W-1:0] depth;
    } t_probe_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // position_key, score, move_code, bound_type, search_generation, search_depth
    logic [151:0]          s_axis_tdata;
    // operation
    logic [0:0]            s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // found_score, found_move, found_type, found_depth
    logic [71:0]           m_axis_tdata;
    // hit
    logic [0:0]            m_axis_tuser;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    t_entry                    tt_model [ENTRY_COUNT];
    logic [MATE_W-1:0]         mate_limit;
    logic signed [SCORE_W-1:0] draw_value;
    logic signed [SCORE_W-1:0] infinity_value;
    logic [BTYPE_W-1:0]        alpha_code;
    logic [MOVE_W-1:0]         null_move;

    t_probe_result expected_probes [$];

    int  cycle_count    = 0;
    int  mismatches     = 0;
    int  requests_sent  = 0;
    int  results_seen   = 0;
    int  hits_seen      = 0;
    int  stores_written = 0;
    int  shallow_stores = 0;
    int  config_rounds  = 0;
    int  burst_left     = 0;
    bit  valid_held     = 1'b0;
    int  ready_pct      = 0;
    int  ready_left     = 0;

    set_assoc_transposition_table_core #(
        .SET_BITS (SETS_LOG2),
        .WAYS     (WAY_COUNT)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("set_assoc_transposition_table_core_tb failed");
            $finish;
        end
    end

    task automatic flag_mismatch(input string msg);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    function automatic void predict_table_access(
        input logic                      op,
        input logic [63:0]               key,
        input logic signed [SCORE_W-1:0] score,
        input logic [MOVE_W-1:0]         mv,
        input logic [BTYPE_W-1:0]        btype,
        input logic [GEN_W-1:0]          gen,
        input logic signed [DEPTH_W-1:0] depth
    );
        int                 base;
        logic [TAG_W-1:0]   tag;
        int                 match_way;
        int                 victim;
        int                 shallowest;
        int                 d;
        logic [SCORE_W-1:0] new_score;
        logic [BTYPE_W-1:0] new_type;
        logic [MOVE_W-1:0]  new_move;
        t_probe_result      res;

        base = int'(key[SETS_LOG2-1:0]) * WAY_COUNT;
        tag = key[63:32];
        match_way = -1;
        for (int w = WAY_COUNT - 1; w >= 0; w--)
            if (tt_model[base + w].tag == tag)
                match_way = w;

        if (op == OP_LOOKUP) begin
            res = '0;
            if (match_way >= 0) begin
                res.hit   = 1'b1;
                res.score = tt_model[base + match_way].score;
                res.move  = tt_model[base + match_way].move;
                res.btype = tt_model[base + match_way].btype;
                res.depth = tt_model[base + match_way].depth;
            end
            expected_probes.push_back(res);
            return;
        end

        if (depth < 8'sd1) begin
            shallow_stores++;
            return;
        end

        new_score = score;
        new_type = btype;
        new_move = mv;
        // mate and draw scores are never kept as they are
        if (longint'(score) >= longint'(mate_limit) || longint'(score) <= -longint'(mate_limit)
                || score == draw_value) begin
            new_score = infinity_value;
            new_type = alpha_code;
        end

        victim = -1;
        if (match_way >= 0) begin
            victim = match_way;
            if (mv == null_move)
                new_move = tt_model[base + match_way].move;
        end else begin
            shallowest = NO_DEPTH;
            for (int w = 0; w < WAY_COUNT; w++) begin
                d = int'($signed(tt_model[base + w].depth));
                if (tt_model[base + w].gen != gen && shallowest > d) begin
                    shallowest = d;
                    victim = w;
                end
            end
            if (victim < 0) begin
                shallowest = NO_DEPTH;
                for (int w = 0; w < WAY_COUNT; w++) begin
                    d = int'($signed(tt_model[base + w].depth));
                    if (shallowest > d) begin
                        shallowest = d;
                        victim = w;
                    end
                end
            end
        end

        tt_model[base + victim] = '{tag: tag, score: new_score, move: new_move,
                                    btype: new_type, depth: depth, gen: gen};
        stores_written++;
    endfunction

    task automatic issue_request(
        input logic                      op,
        input logic [63:0]               key,
        input logic signed [SCORE_W-1:0] score,
        input logic [MOVE_W-1:0]         mv,
        input logic [BTYPE_W-1:0]        btype,
        input logic [GEN_W-1:0]          gen,
        input logic signed [DEPTH_W-1:0] depth
    );
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {depth, gen, btype, mv, score, key};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        predict_table_access(op, key, score, mv, btype, gen, depth);
        requests_sent++;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            s_axis_tvalid <= 1'b0;
            valid_held = 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end else begin
            valid_held = 1'b1;
        end
    endtask

    task automatic store_entry(
        input logic [63:0]               key,
        input logic signed [SCORE_W-1:0] score,
        input logic [MOVE_W-1:0]         mv,
        input logic [BTYPE_W-1:0]        btype,
        input logic [GEN_W-1:0]          gen,
        input logic signed [DEPTH_W-1:0] depth
    );
        issue_request(OP_STORE, key, score, mv, btype, gen, depth);
    endtask

    // store-only fields carry noise on a lookup
    task automatic probe_entry(input logic [63:0] key);
        issue_request(OP_LOOKUP, key, SCORE_W'($urandom), MOVE_W'($urandom),
                      BTYPE_W'($urandom), GEN_W'($urandom), DEPTH_W'($urandom));
    endtask

    // stores give no result, so allow the write-back to finish before going on
    task automatic settle_table();
        if (valid_held) begin
            s_axis_tvalid <= 1'b0;
            valid_held = 1'b0;
        end
        while (expected_probes.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_registers(
        input logic [MATE_W-1:0]         mate,
        input logic signed [SCORE_W-1:0] draw,
        input logic signed [SCORE_W-1:0] infinity,
        input logic [BTYPE_W-1:0]        alpha,
        input logic [MOVE_W-1:0]         nullmv
    );
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_MATE_THRESHOLD;
        i_cfg_data <= {1'($urandom_range(0, 1)), mate};
        @(posedge i_clk);
        i_cfg_index <= CFG_DRAW_SCORE;
        i_cfg_data <= draw;
        @(posedge i_clk);
        i_cfg_index <= CFG_INFINITY_SCORE;
        i_cfg_data <= infinity;
        @(posedge i_clk);
        i_cfg_index <= CFG_ALPHA_TYPE_CODE;
        i_cfg_data <= {24'($urandom), alpha};
        @(posedge i_clk);
        i_cfg_index <= CFG_NULL_MOVE_CODE;
        i_cfg_data <= {8'($urandom), nullmv};
        @(posedge i_clk);
        i_cfg_index <= CFG_UNUSED_INDEX;
        i_cfg_data <= $urandom;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        mate_limit = mate;
        draw_value = draw;
        infinity_value = infinity;
        alpha_code = alpha;
        null_move = nullmv;
        config_rounds++;
    endtask

    task automatic test_cleared_entries();
        probe_entry(64'h0000_0000_0000_0000);
        probe_entry(64'h0000_0000_ffff_f123);
        probe_entry(64'h8000_0000_0000_0000);
    endtask

    task automatic test_shallow_stores();
        store_entry(64'h5555_aaaa_0000_0555, 32'sd100, 24'h00_0abc, 8'h05, 16'h0001, 8'sd0);
        store_entry(64'h5555_aaaa_0000_0555, 32'sd100, 24'h00_0abc, 8'h05, 16'h0001, -8'sd128);
        probe_entry(64'h5555_aaaa_0000_0555);
    endtask

    task automatic test_score_substitution();
        store_entry(64'hffff_ffff_ffff_ffff, 32'sd1234, 24'hff_ffff, 8'hff, 16'hffff, 8'sd127);
        store_entry(64'h7654_3210_0000_0abc, 32'sd0, 24'h12_3456, 8'h04, 16'h0001, 8'sd3);
        store_entry(64'h0123_4567_89ab_c001, -32'sd30000, 24'h00_0001, 8'h02, 16'h0001, 8'sd1);
        probe_entry(64'hffff_ffff_ffff_ffff);
        probe_entry(64'h7654_3210_0000_0abc);
        probe_entry(64'h0123_4567_89ab_c001);
    endtask

    task automatic test_null_move_keeps_move();
        store_entry(64'hffff_ffff_ffff_ffff, 32'sd77, null_move, 8'h33, 16'h0002, 8'sd10);
        probe_entry(64'hffff_ffff_ffff_ffff);
    endtask

    // fill one set, then evict by depth within and across generations
    task automatic test_victim_choice();
        store_entry(64'h1000_0001_0000_03c1, 32'sd11, 24'h00_0011, 8'h01, 16'h0007, 8'sd5);
        store_entry(64'h1000_0002_0000_03c1, 32'sd12, 24'h00_0012, 8'h02, 16'h0007, 8'sd3);
        store_entry(64'h1000_0003_0000_03c1, 32'sd13, 24'h00_0013, 8'h03, 16'h0007, 8'sd3);
        store_entry(64'h1000_0004_0000_03c1, 32'sd14, 24'h00_0014, 8'h04, 16'h0007, 8'sd9);
        store_entry(64'h1000_0005_0000_03c1, 32'sd15, 24'h00_0015, 8'h05, 16'h0007, 8'sd6);
        store_entry(64'h1000_0006_0000_03c1, 32'sd16, 24'h00_0016, 8'h06, 16'h0008, 8'sd2);
        probe_entry(64'h1000_0002_0000_03c1);
        probe_entry(64'h1000_0006_0000_03c1);
    endtask

    task automatic test_register_extremes();
        settle_table();
        program_registers('0, 32'sh8000_0000, 32'sh8000_0000, 8'h00, 24'hff_ffff);
        store_entry(64'h2468_ace0_1357_9bdf, -32'sd5, 24'hff_ffff, 8'h77, 16'h0000, 8'sd2);
        probe_entry(64'h2468_ace0_1357_9bdf);
        settle_table();
        program_registers(31'h7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 8'hff, 24'h00_0000);
        store_entry(64'h1357_9bdf_2468_ace0, 32'sh8000_0000, 24'h00_0000, 8'h10, 16'h8000,
                    8'sd64);
        probe_entry(64'h1357_9bdf_2468_ace0);
        settle_table();
        program_registers(RST_MATE_THRESHOLD, RST_DRAW_SCORE, RST_INFINITY_SCORE,
                          RST_ALPHA_TYPE_CODE, RST_NULL_MOVE_CODE);
    endtask

    // traffic focused on a few sets and tags so that hits and evictions are common
    task automatic test_random_traffic();
        logic [SETS_LOG2-1:0]      set_pool [6];
        logic [TAG_W-1:0]          tag_pool [10];
        logic [GEN_W-1:0]          gen_base;
        logic [SETS_LOG2-1:0]      set_idx;
        logic [TAG_W-1:0]          tag;
        logic                      op;
        logic signed [SCORE_W-1:0] score;
        logic [MOVE_W-1:0]         mv;
        logic [GEN_W-1:0]          gen;
        logic signed [DEPTH_W-1:0] depth;
        longint                    score_l;
        int                        taken;

        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            settle_table();
            case ($urandom_range(0, 2))
                0: mate_limit = MATE_W'($urandom_range(1, 40000));
                1: mate_limit = MATE_W'($urandom_range(0, 300));
                default: mate_limit = MATE_W'($urandom);
            endcase
            case ($urandom_range(0, 2))
                0: draw_value = '0;
                1: draw_value = int'($urandom_range(0, 2000)) - 1000;
                default: draw_value = $urandom;
            endcase
            program_registers(mate_limit, draw_value, $urandom, BTYPE_W'($urandom),
                              ($urandom_range(0, 1) != 0) ? 24'($urandom_range(0, 15)) :
                                                            24'($urandom));
            foreach (set_pool[i])
                set_pool[i] = SETS_LOG2'($urandom);
            foreach (tag_pool[i])
                tag_pool[i] = (i == 0) ? '0 : $urandom;
            gen_base = GEN_W'($urandom);
            taken = 0;
            while (taken < PHASE_ITEMS) begin
                if ($urandom_range(0, 99) == 0)
                    gen_base++;
                set_idx = ($urandom_range(0, 4) != 0) ? set_pool[$urandom_range(0, 5)] :
                                                       SETS_LOG2'($urandom);
                tag = ($urandom_range(0, 6) != 0) ? tag_pool[$urandom_range(0, 9)] : $urandom;
                op = 1'($urandom_range(0, 1));
                case ($urandom_range(0, 7))
                    0: score_l = longint'(mate_limit);
                    1: score_l = -longint'(mate_limit);
                    2: score_l = longint'(mate_limit) - 1;
                    3: score_l = 1 - longint'(mate_limit);
                    4: score_l = longint'(draw_value);
                    5: score_l = longint'(int'($urandom_range(0, 60000)) - 30000);
                    default: score_l = longint'($signed($urandom));
                endcase
                score = score_l[SCORE_W-1:0];
                mv = ($urandom_range(0, 4) == 0) ? null_move : MOVE_W'($urandom);
                gen = ($urandom_range(0, 6) != 0) ? gen_base + GEN_W'($urandom_range(0, 1)) :
                                                   GEN_W'($urandom);
                depth = ($urandom_range(0, 6) != 0) ? DEPTH_W'($urandom_range(1, 127)) :
                                                     DEPTH_W'($urandom);
                issue_request(op, {tag, 20'($urandom), set_idx}, score, mv, BTYPE_W'($urandom),
                              gen, depth);
                if (op == OP_LOOKUP || depth >= 8'sd1)
                    taken++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (ready_left == 0) begin
            case ($urandom_range(0, 4))
                0: ready_pct = 100;
                1: ready_pct = 75;
                2: ready_pct = 50;
                3: ready_pct = 15;
                default: ready_pct = 0;
            endcase
            ready_left = (ready_pct == 0) ? $urandom_range(1, 12) : $urandom_range(4, 60);
        end
        ready_left--;
        m_axis_tready <= ($urandom_range(1, 100) <= ready_pct);
    end

    always @(posedge i_clk) begin
        t_probe_result got;
        t_probe_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.hit = m_axis_tuser[0];
            got.score = m_axis_tdata[31:0];
            got.move = m_axis_tdata[55:32];
            got.btype = m_axis_tdata[63:56];
            got.depth = m_axis_tdata[71:64];
            if (expected_probes.size() == 0) begin
                flag_mismatch("lookup result with no lookup outstanding");
            end else begin
                want = expected_probes.pop_front();
                results_seen++;
                if (got.hit === 1'b1)
                    hits_seen++;
                if (got.hit !== want.hit)
                    flag_mismatch($sformatf("result %0d hit %b, expected %b",
                                            results_seen, got.hit, want.hit));
                if (got.score !== want.score)
                    flag_mismatch($sformatf("result %0d score %0d, expected %0d",
                                            results_seen, got.score, want.score));
                if (got.move !== want.move)
                    flag_mismatch($sformatf("result %0d move %h, expected %h",
                                            results_seen, got.move, want.move));
                if (got.btype !== want.btype)
                    flag_mismatch($sformatf("result %0d type %h, expected %h",
                                            results_seen, got.btype, want.btype));
                if (got.depth !== want.depth)
                    flag_mismatch($sformatf("result %0d depth %0d, expected %0d",
                                            results_seen, got.depth, want.depth));
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        foreach (tt_model[i])
            tt_model[i] = '0;
        mate_limit = RST_MATE_THRESHOLD;
        draw_value = RST_DRAW_SCORE;
        infinity_value = RST_INFINITY_SCORE;
        alpha_code = RST_ALPHA_TYPE_CODE;
        null_move = RST_NULL_MOVE_CODE;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_cleared_entries();
        test_shallow_stores();
        test_score_substitution();
        test_null_move_keeps_move();
        test_victim_choice();
        test_register_extremes();
        test_random_traffic();
        settle_table();

        if (expected_probes.size() != 0)
            flag_mismatch($sformatf("%0d lookup results never arrived", expected_probes.size()));
        $display("%0d requests: %0d lookups checked with %0d hits, %0d stores written, %0d shallow",
                 requests_sent, results_seen, hits_seen, stores_written, shallow_stores);
        $display("%0d register settings incl. both extremes, %0d mismatches",
                 config_rounds, mismatches);
        if (mismatches == 0)
            $display("set_assoc_transposition_table_core_tb passed");
        else
            $display("set_assoc_transposition_table_core_tb failed");
        $finish;
    end

endmodule
